// ===== design/ipv6_text_address_parser_assert.svh =====
// assertion macros for the parser rtl
`ifndef IPV6_TEXT_ADDRESS_PARSER_ASSERT_SVH
`define IPV6_TEXT_ADDRESS_PARSER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define IPV6TP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ipv6 parser check failed");

// next-cycle implication, checked out of reset
`define IPV6TP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ipv6 parser check failed");

`endif

// ===== design/ipv6tp_pkg.sv =====
`timescale 1ns / 1ps
package ipv6tp_pkg;

  localparam int MAX_TEXT_LEN = 39;
  localparam int CNT_W        = $clog2(MAX_TEXT_LEN + 1);
  localparam int NUM_GROUPS   = 8;
  localparam int TAIL_DEPTH   = 7;
  localparam int GROUP_W      = 16;
  localparam int MAX_DIGITS   = 4;

  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_NUL   = 8'h00;

  // parse phase, one-hot
  typedef enum logic [2:0] {
    MODE_FWD  = 3'b001,
    MODE_TAIL = 3'b010,
    MODE_DONE = 3'b100
  } mode_t;

  // tail entry: bit 16 marks a bad group, entry 0 is the rightmost
  typedef logic [TAIL_DEPTH-1:0][GROUP_W:0] tail_t;

  // scanner state that is cleared after every result
  typedef struct packed {
    logic [CNT_W-1:0]                     char_count;
    logic [GROUP_W-1:0]                   group_value;
    logic [2:0]                           group_digits;
    logic                                 group_bad;
    logic [NUM_GROUPS-1:0][GROUP_W-1:0]   fwd_groups;
    logic [3:0]                           fwd_index;
    logic [2:0]                           tail_count;
    mode_t                                mode;
    logic                                 prev_colon;
    logic                                 error_seen;
  } scan_t;

  localparam scan_t SCAN_RESET = '{
    char_count:   '0,
    group_value:  '0,
    group_digits: '0,
    group_bad:    1'b0,
    fwd_groups:   '0,
    fwd_index:    '0,
    tail_count:   '0,
    mode:         MODE_FWD,
    prev_colon:   1'b0,
    error_seen:   1'b0
  };

endpackage

// ===== design/ipv6tp_scan.sv =====
`timescale 1ns / 1ps
module ipv6tp_scan (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  logic [7:0]           character,
  input  logic                 no_char,
  input  logic                 last,
  output ipv6tp_pkg::scan_t    fed_state,
  output ipv6tp_pkg::tail_t    fed_tail
);
  import ipv6tp_pkg::*;

  scan_t              state_r;
  tail_t              tail_r;
  logic               nul_r;
  logic               nul_nxt;
  logic [3:0]         nib;
  logic               is_hex;
  logic [GROUP_W-1:0] dig_value;
  logic [2:0]         dig_digits;
  logic               dig_bad;
  logic [2:0]         push_count;

  // hex digit decode
  always_comb begin
    nib    = 4'h0;
    is_hex = 1'b1;
    if (character >= 8'h30 && character <= 8'h39) begin
      nib = 4'(character - 8'h30);
    end else if (character >= 8'h61 && character <= 8'h66) begin
      nib = 4'(character - 8'h57);
    end else if (character >= 8'h41 && character <= 8'h46) begin
      nib = 4'(character - 8'h37);
    end else begin
      is_hex = 1'b0;
    end
  end

  // group update for a digit character
  always_comb begin
    dig_bad    = state_r.group_bad | ~is_hex;
    dig_digits = state_r.group_digits;
    if (state_r.group_digits >= 3'(MAX_DIGITS)) begin
      dig_bad = 1'b1;
    end else begin
      dig_digits = state_r.group_digits + 3'd1;
    end
    dig_value = {state_r.group_value[GROUP_W-5:0], nib};
  end

  assign push_count = (state_r.tail_count == 3'(TAIL_DEPTH)) ?
                      state_r.tail_count : state_r.tail_count + 3'd1;

  // state after this item's character
  always_comb begin
    fed_state = state_r;
    fed_tail  = tail_r;
    nul_nxt   = nul_r;
    if (!no_char && !nul_r) begin
      if (character == CHAR_NUL) begin
        nul_nxt = 1'b1;
      end else begin
        if (state_r.char_count >= CNT_W'(MAX_TEXT_LEN)) begin
          fed_state.error_seen = 1'b1;
        end else begin
          fed_state.char_count = state_r.char_count + CNT_W'(1);
        end
        case (state_r.mode)
          MODE_FWD: begin
            if (character == CHAR_COLON) begin
              if (state_r.prev_colon) begin
                fed_state.mode       = MODE_TAIL;
                fed_state.prev_colon = 1'b0;
              end else begin
                if (state_r.group_bad) begin
                  fed_state.error_seen = 1'b1;
                end
                fed_state.fwd_groups[state_r.fwd_index[2:0]] = state_r.group_value;
                fed_state.fwd_index    = state_r.fwd_index + 4'd1;
                fed_state.group_value  = '0;
                fed_state.group_digits = '0;
                fed_state.group_bad    = 1'b0;
                if (state_r.fwd_index == 4'(NUM_GROUPS - 1)) begin
                  fed_state.mode = MODE_DONE;
                end else begin
                  fed_state.prev_colon = 1'b1;
                end
              end
            end else begin
              fed_state.prev_colon   = 1'b0;
              fed_state.group_value  = dig_value;
              fed_state.group_digits = dig_digits;
              fed_state.group_bad    = dig_bad;
            end
          end
          MODE_TAIL: begin
            if (character == CHAR_COLON) begin
              fed_tail               = {tail_r[TAIL_DEPTH-2:0],
                                        {state_r.group_bad, state_r.group_value}};
              fed_state.tail_count   = push_count;
              fed_state.group_value  = '0;
              fed_state.group_digits = '0;
              fed_state.group_bad    = 1'b0;
            end else begin
              fed_state.group_value  = dig_value;
              fed_state.group_digits = dig_digits;
              fed_state.group_bad    = dig_bad;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // control state, cleared after each result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SCAN_RESET;
      nul_r   <= 1'b0;
    end else if (step) begin
      state_r <= last ? SCAN_RESET : fed_state;
      nul_r   <= last ? 1'b0 : nul_nxt;
    end
  end

  // tail group storage, only read below its count
  always_ff @(posedge clk) begin
    if (step) begin
      tail_r <= fed_tail;
    end
  end

endmodule

// ===== design/ipv6tp_assemble.sv =====
`timescale 1ns / 1ps
module ipv6tp_assemble (
  input  ipv6tp_pkg::scan_t  fed_state,
  input  ipv6tp_pkg::tail_t  fed_tail,
  output logic [63:0]        addr_high,
  output logic [63:0]        addr_low,
  output logic               valid_res
);
  import ipv6tp_pkg::*;

  logic [NUM_GROUPS-1:0][GROUP_W-1:0] g;
  tail_t                              pt;
  logic [2:0]                         cnt;
  logic                               ok;

  // closing group pushed onto the tail
  assign pt  = {fed_tail[TAIL_DEPTH-2:0], {fed_state.group_bad, fed_state.group_value}};
  assign cnt = (fed_state.tail_count == 3'(TAIL_DEPTH)) ?
               fed_state.tail_count : fed_state.tail_count + 3'd1;

  // merge forward and tail groups, check the closing group
  always_comb begin
    g  = fed_state.fwd_groups;
    ok = ~fed_state.error_seen;
    case (fed_state.mode)
      MODE_FWD: begin
        if (fed_state.fwd_index == 4'(NUM_GROUPS - 1) && !fed_state.group_bad) begin
          g[NUM_GROUPS-1] = fed_state.group_value;
        end else begin
          ok = 1'b0;
        end
      end
      MODE_TAIL: begin
        for (int k = 0; k < TAIL_DEPTH; k++) begin
          if (3'(k) < cnt) begin
            if (pt[k][GROUP_W]) begin
              ok = 1'b0;
            end
            g[NUM_GROUPS-1-k] = pt[k][GROUP_W-1:0];
          end
        end
      end
      default: ;
    endcase
  end

  // group 0 lands in the top bits
  assign addr_high = ok ? {g[0], g[1], g[2], g[3]} : 64'd0;
  assign addr_low  = ok ? {g[4], g[5], g[6], g[7]} : 64'd0;
  assign valid_res = ok;

endmodule

// ===== design/ipv6_text_address_parser.sv =====
`timescale 1ns / 1ps
// IPv6 text address parser. Feed the address text one ASCII character per item
// and flag the final item with in_last; an item with in_no_char set carries no
// character (use it with in_last to close the text). One item is taken every
// cycle while in_stall is low; the result for a string reaches the out_ channel
// through the input register, the scan and assembly logic and then the result
// register. out_stall only holds back the input at an item flagged last while
// an earlier result is still waiting. A rejected string gives out_valid_res
// low and a zero address; texts over 39 characters, groups over four digits,
// bad hex digits and too few groups without a double colon are rejected, and
// a zero byte ends the text early.
module ipv6_text_address_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_character,
  input  logic        in_no_char,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_addr_high,
  output logic [63:0] out_addr_low,
  output logic        out_valid_res
);
  import ipv6tp_pkg::*;

  logic        inv_r;
  logic [7:0]  char_r;
  logic        no_char_r;
  logic        last_r;
  logic        out_valid_r;
  logic [63:0] addr_high_r;
  logic [63:0] addr_low_r;
  logic        valid_res_r;
  logic        out_free;
  logic        s1_go;
  logic        out_load;
  logic        in_take;
  scan_t       fed_state;
  tail_t       fed_tail;
  logic [63:0] asm_high;
  logic [63:0] asm_low;
  logic        asm_ok;

  // handshake control
  assign out_free = ~out_valid_r | ~out_stall;
  assign s1_go    = inv_r & (~last_r | out_free);
  assign out_load = s1_go & last_r;
  assign in_stall = inv_r & ~s1_go;
  assign in_take  = in_valid & ~in_stall;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_r <= 1'b0;
    end else if (!in_stall) begin
      inv_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      char_r    <= in_character;
      no_char_r <= in_no_char;
      last_r    <= in_last;
    end
  end

  ipv6tp_scan u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (s1_go),
    .character (char_r),
    .no_char   (no_char_r),
    .last      (last_r),
    .fed_state (fed_state),
    .fed_tail  (fed_tail)
  );

  ipv6tp_assemble u_assemble (
    .fed_state (fed_state),
    .fed_tail  (fed_tail),
    .addr_high (asm_high),
    .addr_low  (asm_low),
    .valid_res (asm_ok)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      addr_high_r <= asm_high;
      addr_low_r  <= asm_low;
      valid_res_r <= asm_ok;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_addr_high = addr_high_r;
  assign out_addr_low  = addr_low_r;
  assign out_valid_res = valid_res_r;

  `include "ipv6_text_address_parser_assert.svh"

  // checks
  `IPV6TP_ASSERT_NOW(a_reject_zero, out_valid_r && !valid_res_r, addr_high_r == 64'd0 && addr_low_r == 64'd0)
  `IPV6TP_ASSERT_NOW(a_stall_only_held, in_stall, inv_r && last_r && out_valid_r)
  `IPV6TP_ASSERT_NEXT(a_last_gives_result, s1_go && last_r, out_valid_r)

endmodule
